FILE: rtl/swo_pkg.sv
// ----------------------------------------------------------------------------
// Skewed waveform oscillator package
// Beat types, configuration layout, register codes and shared constants.
// ----------------------------------------------------------------------------
package swo_pkg;

  // Input beat: one sample tick with its three modulation samples.
  typedef struct packed {
    logic signed [15:0] freq_mod;
    logic signed [15:0] volume_mod;
    logic signed [15:0] skew_mod;
  } swo_in_t;

  // Output beat: one oscillator sample and its clamp flag.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clipped;
  } swo_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic        [1:0]  waveform;
    logic        [22:0] base_freq;
    logic        [22:0] freq_range;
    logic        [14:0] base_volume;
    logic        [14:0] volume_range;
    logic signed [15:0] base_skew;
    logic        [14:0] skew_range;
  } swo_cfg_t;

  // Register index, taken from the word address.
  typedef enum logic [2:0] {
    REG_WAVEFORM     = 3'd0,
    REG_BASE_FREQ    = 3'd1,
    REG_FREQ_RANGE   = 3'd2,
    REG_BASE_VOLUME  = 3'd3,
    REG_VOLUME_RANGE = 3'd4,
    REG_BASE_SKEW    = 3'd5,
    REG_SKEW_RANGE   = 3'd6
  } swo_reg_e;

  // Waveform codes; any other code selects the rectangle.
  localparam logic [1:0] WaveSine     = 2'd0;
  localparam logic [1:0] WaveTriangle = 2'd1;

  // Register reset values.
  localparam logic [22:0] BaseFreqReset   = 23'd112640;
  localparam logic [14:0] BaseVolumeReset = 15'd16384;

  // Shared divider geometry.
  localparam int DivW     = 56;
  localparam int DivisorW = 32;
  localparam int DivCntW  = 6;

endpackage

FILE: rtl/swo_div.sv
// ----------------------------------------------------------------------------
// Shared radix-2 divider
// Restoring division, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of steps are run.
// ----------------------------------------------------------------------------
module swo_div import swo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  input  logic [DivCntW-1:0]  steps_i,
  output logic                done_o,
  output logic [DivW-1:0]     quotient_o
);

  logic                busy_q;
  logic                done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [DivW-1:0]     dvd_q;
  logic [DivW-1:0]     quo_q;
  logic [DivisorW-1:0] den_q;
  logic [DivisorW-1:0] rem_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  logic [DivisorW:0] rem_sh;
  logic              fits;
  logic [DivisorW:0] rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DivW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      rem_q <= fits ? rem_sub[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/swo_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Holds round(32768 * sin(pi/2 * k / depth)) for k = 0..depth, built at
// elaboration by a Q29 Taylor series. The read data is registered.
// ----------------------------------------------------------------------------
module swo_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_i,
  output logic [15:0]                           data_o
);

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH+1];

  localparam longint unsigned HalfPiQ29 = 64'd843314857;
  localparam longint unsigned TaylorDiv [12] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  // Taylor series of sin over the first quadrant, rounded to Q1.15.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = HalfPiQ29 * longint'(k) / SINE_TABLE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 29;
        term = (term * x) >> 29;
        term = term / TaylorDiv[n-1];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) + 64'd8192) >> 14;
      if (v > 64'd32768 || k == SINE_TABLE_DEPTH) begin
        v = 64'd32768;
      end
      rom[k] = v[15:0];
    end
    return rom;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [15:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Rom[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: rtl/swo_cfg.sv
// ----------------------------------------------------------------------------
// Oscillator configuration registers
// APB-style register file with seven registers at word addresses.
// ----------------------------------------------------------------------------
module swo_cfg import swo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output swo_cfg_t    cfg_o
);

  swo_cfg_t cfg_q;
  swo_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = swo_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform     <= WaveSine;
      cfg_q.base_freq    <= BaseFreqReset;
      cfg_q.freq_range   <= '0;
      cfg_q.base_volume  <= BaseVolumeReset;
      cfg_q.volume_range <= '0;
      cfg_q.base_skew    <= '0;
      cfg_q.skew_range   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WAVEFORM:     cfg_q.waveform     <= pwdata[1:0];
        REG_BASE_FREQ:    cfg_q.base_freq    <= pwdata[22:0];
        REG_FREQ_RANGE:   cfg_q.freq_range   <= pwdata[22:0];
        REG_BASE_VOLUME:  cfg_q.base_volume  <= pwdata[14:0];
        REG_VOLUME_RANGE: cfg_q.volume_range <= pwdata[14:0];
        REG_BASE_SKEW:    cfg_q.base_skew    <= $signed(pwdata[15:0]);
        REG_SKEW_RANGE:   cfg_q.skew_range   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_WAVEFORM:     prdata = {30'b0, cfg_q.waveform};
      REG_BASE_FREQ:    prdata = {9'b0, cfg_q.base_freq};
      REG_FREQ_RANGE:   prdata = {9'b0, cfg_q.freq_range};
      REG_BASE_VOLUME:  prdata = {17'b0, cfg_q.base_volume};
      REG_VOLUME_RANGE: prdata = {17'b0, cfg_q.volume_range};
      REG_BASE_SKEW:    prdata = {16'b0, cfg_q.base_skew};
      REG_SKEW_RANGE:   prdata = {17'b0, cfg_q.skew_range};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/skewed_waveform_oscillator_unit.sv
// The shared radix-2 divider sets the time from input beat to output beat: samples per
// period takes clog2(SAMPLE_RATE+1)+24 steps, the position 56, the skew segment 47 (sine)
// or 40 (triangle).
// The block takes no new beat before the last is through: the input stalls while a beat is in
// progress, and an output beat that is not taken holds the block until it is.
// Reset: registers take their reset values and the phase clears to zero at once.
// ----------------------------------------------------------------------------
// Skewed waveform oscillator
// Phase accumulator oscillator with variable symmetry, built around one
// shared multiplier and one shared divider under a small sequencer.
// ----------------------------------------------------------------------------
module skewed_waveform_oscillator_unit import swo_pkg::*; #(
  parameter int SAMPLE_RATE      = 48000,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  swo_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output swo_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FreqMax  = SAMPLE_RATE * 128;
  localparam int FreqW    = $clog2(FreqMax + 1);
  localparam int IdxW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SppSteps = $clog2(SAMPLE_RATE + 1) + 24;
  localparam logic [DivW-1:0] SppDividend =
    DivW'(SAMPLE_RATE) << (DivW + 24 - SppSteps);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_F, S_FREQ, S_VOL, S_SKEW, S_SPP_WAIT, S_PHASE, S_U_WAIT,
    S_SEG, S_SEG_WAIT, S_IDX_MUL, S_ROM_ADDR, S_ROM_DATA, S_OUT_MUL, S_DONE
  } state_e;

  swo_cfg_t cfg;

  state_e             state_q;
  swo_in_t            in_q;
  logic               clip_q;
  logic [FreqW-1:0]   freq_q;
  logic signed [17:0] vol_q;
  logic [15:0]        p_q;
  logic [31:0]        spp_q;
  logic [31:0]        phase_q;
  logic [23:0]        u_q;
  logic               below_q;
  logic [23:0]        a_q;
  logic signed [16:0] wave_q;
  logic signed [41:0] prod_q;
  logic               out_valid_q;
  swo_out_t           out_q;

  // Configuration registers.
  swo_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Shared multiplier with a registered product.
  logic signed [23:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    case (state_q)
      S_MUL_F: begin
        mul_a = $signed({1'b0, cfg.freq_range});
        mul_b = 18'(in_q.freq_mod);
      end
      S_FREQ: begin
        mul_a = $signed({9'b0, cfg.volume_range});
        mul_b = 18'(in_q.volume_mod);
      end
      S_VOL: begin
        mul_a = $signed({9'b0, cfg.skew_range});
        mul_b = 18'(in_q.skew_mod);
      end
      S_IDX_MUL: begin
        mul_a = $signed({2'b0, a_q[21:0]});
        mul_b = 18'(SINE_TABLE_DEPTH);
      end
      default: begin
        mul_a = 24'(wave_q);
        mul_b = vol_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Floor of the product over 32768.
  logic signed [26:0] prod_fl;
  assign prod_fl = prod_q[41:15];

  // Modulated parameters.
  logic signed [26:0] freq_sum;
  logic signed [17:0] vol_sum;
  logic signed [17:0] p_sum;

  assign freq_sum = $signed({4'b0, cfg.base_freq}) + prod_fl;
  assign vol_sum  = $signed({3'b0, cfg.base_volume}) + prod_fl[17:0];
  assign p_sum    = 18'(cfg.base_skew) + prod_fl[17:0] + 18'sd32768;

  // Phase step with a single wrap.
  logic [32:0] ph_sum;
  logic [32:0] ph_wrap;
  assign ph_sum  = {1'b0, phase_q} + 33'd65536;
  assign ph_wrap = (ph_sum >= {1'b0, spp_q}) ? ph_sum - {1'b0, spp_q} : ph_sum;

  // Skew segment selection.
  logic [23:0] pw;
  logic        below;
  logic [23:0] seg_x;
  logic [24:0] seg_len;
  assign pw      = {p_q, 8'b0};
  assign below   = u_q < pw;
  assign seg_x   = below ? u_q : u_q - pw;
  assign seg_len = below ? {1'b0, pw} : 25'h1000000 - {1'b0, pw};

  // Shared divider operand selection.
  logic                div_start;
  logic [DivW-1:0]     div_dividend;
  logic [DivisorW-1:0] div_divisor;
  logic [DivCntW-1:0]  div_steps;
  logic                div_done;
  logic [DivW-1:0]     div_quo;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {seg_x, 32'b0};
    div_divisor  = 32'(seg_len);
    div_steps    = (cfg.waveform == WaveSine) ? DivCntW'(47) : DivCntW'(40);
    case (state_q)
      S_SKEW: begin
        div_start    = 1'b1;
        div_dividend = SppDividend;
        div_divisor  = 32'(freq_q);
        div_steps    = DivCntW'(SppSteps);
      end
      S_PHASE: begin
        div_start    = 1'b1;
        div_dividend = {ph_wrap[31:0], 24'b0};
        div_divisor  = spp_q;
        div_steps    = DivCntW'(DivW);
      end
      S_SEG: begin
        div_start = (cfg.waveform == WaveSine) || (cfg.waveform == WaveTriangle);
      end
      default: ;
    endcase
  end

  swo_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Quarter-wave lookup address with mirroring in odd quadrants.
  logic [IdxW-1:0] idx_raw;
  logic [IdxW-1:0] rom_addr;
  logic [15:0]     rom_data;
  assign idx_raw  = prod_q[22 +: IdxW];
  assign rom_addr = a_q[22] ? IdxW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;

  swo_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output register: loaded when a beat completes, cleared once taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            clip_q  <= 1'b0;
            state_q <= S_MUL_F;
          end
        end
        S_MUL_F: state_q <= S_FREQ;
        S_FREQ: begin
          if (freq_sum < 27'sd256) begin
            freq_q <= FreqW'(256);
            clip_q <= 1'b1;
          end else if (freq_sum > $signed(27'(FreqMax))) begin
            freq_q <= FreqW'(FreqMax);
            clip_q <= 1'b1;
          end else begin
            freq_q <= freq_sum[FreqW-1:0];
          end
          state_q <= S_VOL;
        end
        S_VOL: begin
          vol_q   <= vol_sum;
          state_q <= S_SKEW;
        end
        S_SKEW: begin
          if (p_sum < 18'sd1) begin
            p_q    <= 16'd1;
            clip_q <= 1'b1;
          end else if (p_sum > 18'sd65535) begin
            p_q    <= 16'd65535;
            clip_q <= 1'b1;
          end else begin
            p_q <= p_sum[15:0];
          end
          state_q <= S_SPP_WAIT;
        end
        S_SPP_WAIT: begin
          if (div_done) begin
            spp_q   <= (|div_quo[DivW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
            state_q <= S_PHASE;
          end
        end
        S_PHASE: begin
          phase_q <= ph_wrap[31:0];
          state_q <= S_U_WAIT;
        end
        S_U_WAIT: begin
          if (div_done) begin
            u_q     <= (|div_quo[DivW-1:24]) ? 24'hFF_FFFF : div_quo[23:0];
            state_q <= S_SEG;
          end
        end
        S_SEG: begin
          below_q <= below;
          if (cfg.waveform == WaveSine || cfg.waveform == WaveTriangle) begin
            state_q <= S_SEG_WAIT;
          end else begin
            wave_q  <= below ? 17'sd32768 : -17'sd32768;
            state_q <= S_OUT_MUL;
          end
        end
        S_SEG_WAIT: begin
          if (div_done) begin
            if (cfg.waveform == WaveSine) begin
              a_q     <= {~below_q, div_quo[22:0]};
              state_q <= S_IDX_MUL;
            end else begin
              wave_q  <= below_q ? $signed({1'b0, div_quo[15:0]}) - 17'sd32768
                                 : 17'sd32768 - $signed({1'b0, div_quo[15:0]});
              state_q <= S_OUT_MUL;
            end
          end
        end
        S_IDX_MUL:  state_q <= S_ROM_ADDR;
        S_ROM_ADDR: state_q <= S_ROM_DATA;
        S_ROM_DATA: begin
          wave_q  <= a_q[23] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
          state_q <= S_OUT_MUL;
        end
        S_OUT_MUL: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            if (prod_fl > 27'sd32767) begin
              out_q.sample  <= 16'sh7FFF;
              out_q.clipped <= 1'b1;
            end else if (prod_fl < -27'sd32768) begin
              out_q.sample  <= -16'sh8000;
              out_q.clipped <= 1'b1;
            end else begin
              out_q.sample  <= prod_fl[15:0];
              out_q.clipped <= clip_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skewed waveform oscillator testbench
// Drives modulation beats under changing register settings and random idling,
// predicts every output sample in a fixed-point oscillator model and compares
// each output beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import swo_pkg::*;

  localparam int RATE       = 48000;
  localparam int ROM_DEPTH  = 1024;
  localparam int HANG_LIMIT = 20000;
  localparam int HOLD_LEN   = 1500;

  // Oscillator predictor and store of pending samples.
  class osc_scoreboard;
    int            rom [ROM_DEPTH+1];
    logic [1:0]    waveform;
    logic [22:0]   base_freq, freq_range;
    logic [14:0]   base_volume, volume_range, skew_range;
    logic signed [15:0] base_skew;
    longint unsigned    phase;
    swo_out_t      pending[$];
    int            mismatches, beats_in, beats_out, clips_seen;

    function void init();
      longint unsigned x, term;
      longint sum, v;
      waveform = 2'd0; base_freq = BaseFreqReset; freq_range = '0;
      base_volume = BaseVolumeReset; volume_range = '0;
      base_skew = '0; skew_range = '0; phase = 0;
      // Quarter-wave table from a Q29 Taylor series.
      for (int k = 0; k <= ROM_DEPTH; k++) begin
        x = 64'd843314857 * k / ROM_DEPTH;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 12; n++) begin
          term = (term * x) >> 29;
          term = (term * x) >> 29;
          term = term / ((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (sum + 8192) >>> 14;
        if (v > 32768 || k == ROM_DEPTH) v = 32768;
        rom[k] = int'(v);
      end
    endfunction

    function void set_reg(swo_reg_e r, logic [31:0] v);
      case (r)
        REG_WAVEFORM:     waveform = v[1:0];
        REG_BASE_FREQ:    base_freq = v[22:0];
        REG_FREQ_RANGE:   freq_range = v[22:0];
        REG_BASE_VOLUME:  base_volume = v[14:0];
        REG_VOLUME_RANGE: volume_range = v[14:0];
        REG_BASE_SKEW:    base_skew = v[15:0];
        REG_SKEW_RANGE:   skew_range = v[14:0];
        default: ;
      endcase
    endfunction

    function longint sine_at(longint unsigned a);
      longint unsigned quad, idx;
      longint v;
      quad = (a >> 22) & 3;
      idx = ((a & 64'h3FFFFF) * ROM_DEPTH) >> 22;
      if (idx > ROM_DEPTH) idx = ROM_DEPTH;
      v = quad[0] ? rom[ROM_DEPTH - idx] : rom[idx];
      return quad[1] ? -v : v;
    endfunction

    // Work out the sample that one accepted beat produces.
    function void note_beat(swo_in_t b);
      longint fq, vol, p16, wave, s;
      longint unsigned spp, ph, u, pt;
      swo_out_t r;
      bit clip;
      clip = 0;
      fq = longint'(base_freq) + ((longint'(freq_range) * longint'(b.freq_mod)) >>> 15);
      if (fq < 256) begin fq = 256; clip = 1; end
      if (fq > RATE * 128) begin fq = RATE * 128; clip = 1; end
      vol = longint'(base_volume)
          + ((longint'(volume_range) * longint'(b.volume_mod)) >>> 15);
      p16 = longint'(base_skew)
          + ((longint'(skew_range) * longint'(b.skew_mod)) >>> 15) + 32768;
      if (p16 < 1) begin p16 = 1; clip = 1; end
      if (p16 > 65535) begin p16 = 65535; clip = 1; end
      pt = longint'(p16) << 8;
      spp = (longint'(RATE) << 24) / fq;
      if (spp > 64'hFFFFFFFF) spp = 64'hFFFFFFFF;
      ph = phase + 65536;
      if (ph >= spp) ph = ph - spp;
      ph = ph & 64'hFFFFFFFF;
      phase = ph;
      u = (ph << 24) / spp;
      if (u >= 64'd16777216) u = 64'd16777215;
      if (waveform == WaveSine) begin
        if (u < pt) wave = sine_at(((u << 23) / pt) & 64'hFFFFFF);
        else wave = sine_at(((64'd1 << 23) + ((u - pt) << 23) / (64'd16777216 - pt))
                            & 64'hFFFFFF);
      end else if (waveform == WaveTriangle) begin
        if (u < pt) wave = longint'((u << 16) / pt) - 32768;
        else wave = 32768 - longint'(((u - pt) << 16) / (64'd16777216 - pt));
      end else begin
        wave = (u < pt) ? 32768 : -32768;
      end
      s = (wave * vol) >>> 15;
      if (s > 32767) begin s = 32767; clip = 1; end
      if (s < -32768) begin s = -32768; clip = 1; end
      r.sample = s[15:0];
      r.clipped = clip;
      pending.push_back(r);
      beats_in++;
    endfunction

    // Compare one output beat with the oldest pending sample.
    function void check_beat(swo_out_t got);
      swo_out_t want;
      beats_out++;
      if (got.clipped) clips_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: sample %0d clipped %0b",
                                       got.sample, got.clipped);
        return;
      end
      want = pending.pop_front();
      if (got.sample !== want.sample || got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                   beats_out, want.sample, want.clipped, got.sample, got.clipped);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  swo_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  swo_out_t    out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  osc_scoreboard osc = new();
  int  tx_idle_pct = 0, rx_idle_pct = 0;
  bit  rx_hold = 1'b0;
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  skewed_waveform_oscillator_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Beat monitors; both sample the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) osc.note_beat(in_data);
    if (rst_n && out_valid && !out_stall) osc.check_beat(out_data);
  end

  // Receiver stalls at random, or for a long stretch while held off.
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > HANG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic reg_write(swo_reg_e r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    osc.set_reg(r, v);
  endtask

  task automatic load_setting(logic [1:0] wf, int bf, int fr, int bv, int vr,
                              int bs, int sr);
    // Stop offering beats; registers change only once the block has drained.
    in_valid <= 1'b0;
    wait (osc.pending.size() == 0);
    reg_write(REG_WAVEFORM, 32'(wf));
    reg_write(REG_BASE_FREQ, bf);
    reg_write(REG_FREQ_RANGE, fr);
    reg_write(REG_BASE_VOLUME, bv);
    reg_write(REG_VOLUME_RANGE, vr);
    reg_write(REG_BASE_SKEW, bs);
    reg_write(REG_SKEW_RANGE, sr);
  endtask

  task automatic send_beat(logic [15:0] fm, logic [15:0] vm, logic [15:0] sm);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {fm, vm, sm};
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [15:0] mod_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int pick_freq();
    case ($urandom_range(4))
      0: return 256;
      1: return 6144000;
      2: return $urandom_range(6144000, 256);
      default: return $urandom_range(500000, 256);
    endcase
  endfunction

  initial begin
    int phase_no;
    osc.init();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting, then the extremes of the modulation fields.
    rx_idle_pct = 30;
    send_beat(16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF);
    // Full-depth modulation: frequency clamps both ways, skew clamps low, volume falls to zero.
    load_setting(WaveSine, 256, 6144000, 32767, 32767, -32768, 32767);
    send_beat(16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(16'h7FFF, 16'h8000, 16'h0000);
    send_beat(16'h0000, 16'h7FFF, 16'h7FFF);
    load_setting(WaveTriangle, 6144000, 6144000, 32767, 32767, 32767, 32767);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h0000, 16'h0000, 16'h0000);
    load_setting(2'd2, 2000000, 0, 32767, 32767, 0, 0);
    repeat (4) send_beat(16'h0000, 16'h7FFF, 16'h0000);
    // Code 3 falls back to the rectangle; base skew at the lower edge clamps.
    load_setting(2'd3, 112640, 0, 0, 32767, -32768, 0);
    repeat (4) send_beat(16'h0000, 16'h8000, 16'h0000);

    // Random settings, each followed by a run of random beats.
    for (phase_no = 0; phase_no < 9; phase_no++) begin
      if (phase_no < 3) begin tx_idle_pct = 23; rx_idle_pct = 59; end
      else if (phase_no < 6) begin tx_idle_pct = 59; rx_idle_pct = 23; end
      else begin tx_idle_pct = 0; rx_idle_pct = 0; end
      load_setting(2'(phase_no % 4), pick_freq(),
                   ($urandom_range(2) == 0) ? 0 : $urandom_range(6144000),
                   $urandom_range(32767), $urandom_range(32767),
                   $urandom_range(65535), $urandom_range(32767));
      if (phase_no == 6) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (HOLD_LEN) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      repeat (45) send_beat(mod_value(), mod_value(), mod_value());
    end
    in_valid <= 1'b0;

    wait (osc.pending.size() == 0);
    repeat (300) @(posedge clk);
    $display("Ran %0d beats over 14 settings of all four waveform codes; %0d samples",
             osc.beats_in, osc.beats_out);
    $display("came back, %0d of them flagged as clamped.", osc.clips_seen);
    if (osc.mismatches == 0 && osc.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
